// ----- sv/lir_pkg.sv -----
// shared types, constants and the microcode program of the resampler
package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 16;
  // time_step always arrives in Q15
  localparam int STEP_FRAC = 15;
  localparam int PH_W     = 17;
  localparam int PROD_W   = 34;
  localparam int ACC_W    = 35;
  localparam int PC_W     = 3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [STEP_W-1:0]          STEP_RESET = 16'h8000;

  typedef logic [PC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_NOT_PRIMED,
    BR_PH_GE_ONE,
    BR_NOT_LAST
  } br_t;

  typedef enum logic [1:0] {
    PH_KEEP,
    PH_ADD,
    PH_WRAP
  } ph_op_t;

  typedef struct packed {
    logic   in_rdy;
    logic   ld_cur;
    logic   ld_prev;
    logic   set_primed;
    logic   mul_en;
    logic   emit;
    ph_op_t ph_op;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    hold_t hold;
    br_t   br;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic primed;
    logic ph_ge_one;
    logic last;
    logic in_valid;
    logic out_free;
  } stat_t;

  localparam upc_t A_WAIT    = 3'd0;
  localparam upc_t A_CHK_PRM = 3'd1;
  localparam upc_t A_CHK_PH  = 3'd2;
  localparam upc_t A_MUL     = 3'd3;
  localparam upc_t A_EMIT    = 3'd4;
  localparam upc_t A_FIN     = 3'd5;
  localparam upc_t A_PRIME   = 3'd6;

  function automatic uword_t ucode_rom(upc_t addr);
    uword_t w;
    w = '0;
    w.ctrl.ph_op = PH_KEEP;
    w.hold = HOLD_NONE;
    w.br = BR_NONE;
    w.target = A_WAIT;
    case (addr)
      A_WAIT: begin
        w.ctrl.in_rdy = 1'b1;
        w.ctrl.ld_cur = 1'b1;
        w.hold = HOLD_IN;
      end
      A_CHK_PRM: begin
        w.br = BR_NOT_PRIMED;
        w.target = A_PRIME;
      end
      A_CHK_PH: begin
        // phase already at or past the end of the period: this input makes no output
        w.br = BR_PH_GE_ONE;
        w.target = A_FIN;
      end
      A_MUL: begin
        w.ctrl.mul_en = 1'b1;
      end
      A_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.ctrl.ph_op = PH_ADD;
        w.hold = HOLD_OUT;
        w.br = BR_NOT_LAST;
        w.target = A_MUL;
      end
      A_FIN: begin
        w.ctrl.ld_prev = 1'b1;
        w.ctrl.ph_op = PH_WRAP;
        w.br = BR_ALWAYS;
        w.target = A_WAIT;
      end
      A_PRIME: begin
        w.ctrl.ld_prev = 1'b1;
        w.ctrl.set_primed = 1'b1;
        w.br = BR_ALWAYS;
        w.target = A_WAIT;
      end
      default: begin
        w.br = BR_ALWAYS;
        w.target = A_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/lir_if.sv -----
// stream interfaces for the input and output items
interface lir_in_if import lir_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface lir_out_if import lir_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last_of_run;

  modport source (output valid, output sample_out, output last_of_run, input ready);
  modport sink   (input valid, input sample_out, input last_of_run, output ready);
endinterface

// ----- sv/linear_interp_resampler.sv -----
// top level of the linear interpolation resampler
//
//   channel    dir  handshake        payload
//   in_chan    in   valid/ready      sample_in (s16)
//   out_chan   out  valid/ready      sample_out (s16), last_of_run
//   cfg        in   cfg_we           cfg_wdata = time_step (u16, Q15)
//
// one item at a time through a 7-step microprogram: the first item after reset
// only primes the previous sample; any other item yields no output, one output
// or two; an output step waits while the output register stays full and
// unread
// the output register lets the next item be taken while a result waits
// reset: synchronous, clears phase, previous sample and the primed flag
module linear_interp_resampler import lir_pkg::*; #(
  parameter int FRAC_BITS = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata,
  lir_in_if.sink            in_chan,
  lir_out_if.source         out_chan
);

  ctrl_t ctrl;
  stat_t stat;

  lir_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  lir_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_chan.valid),
    .sample_in   (in_chan.sample_in),
    .out_ready   (out_chan.ready),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_valid   (out_chan.valid),
    .sample_out  (out_chan.sample_out),
    .last_of_run (out_chan.last_of_run)
  );

  assign in_chan.ready = ctrl.in_rdy;

endmodule

// ----- sv/lir_seq.sv -----
// microcode sequencer: step counter, control store and branch logic
module lir_seq import lir_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  upc_t   pc;
  upc_t   pc_next;
  uword_t word;
  logic   go;
  logic   taken;

  assign word = ucode_rom(pc);

  always_comb begin
    case (word.hold)
      HOLD_IN:  go = stat.in_valid;
      HOLD_OUT: go = stat.out_free;
      default:  go = 1'b1;
    endcase
  end

  always_comb begin
    case (word.br)
      BR_ALWAYS:     taken = 1'b1;
      BR_NOT_PRIMED: taken = ~stat.primed;
      BR_PH_GE_ONE:  taken = stat.ph_ge_one;
      BR_NOT_LAST:   taken = ~stat.last;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    if (!go) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  // actions other than in_rdy fire only once the step's wait condition is met
  always_comb begin
    ctrl = go ? word.ctrl : '0;
    ctrl.in_rdy = word.ctrl.in_rdy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- sv/lir_dp.sv -----
// datapath: sample registers, phase accumulator, multiplier and output register
module lir_dp import lir_pkg::*; #(
  parameter int FRAC_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [STEP_W-1:0]          cfg_wdata,
  input  logic                       in_valid,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       out_ready,
  input  ctrl_t                      ctrl,
  output stat_t                      stat,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       last_of_run
);

  localparam logic [PH_W-1:0]         ONE  = PH_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic [STEP_W-1:0]          time_step;
  logic [PH_W-1:0]            phase;
  logic [PH_W-1:0]            phase_next;
  logic signed [SAMPLE_W-1:0] cur;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic                       primed;
  logic                       cnt;
  logic signed [PROD_W-1:0]   prod;

  logic [PH_W-1:0]            step;
  logic [PH_W-1:0]            ph_sum;
  logic signed [PH_W-1:0]     diff;
  logic signed [PH_W-1:0]     frac;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       ph_ge_one;
  logic                       last;

  assign step      = PH_W'(time_step >> (STEP_FRAC - FRAC_BITS));
  assign ph_sum    = phase + step;
  assign ph_ge_one = phase >= ONE;
  // last output of this input: next phase reaches or leaves the period, or one already out
  assign last      = (ph_sum >= ONE) | cnt;

  assign diff = PH_W'(cur) - PH_W'(previous_sample);
  assign frac = $signed({1'b0, phase[PH_W-2:0]});

  // prev*(one-frac) + cur*frac == prev*one + (cur-prev)*frac
  assign acc     = (ACC_W'(previous_sample) <<< FRAC_BITS) + ACC_W'(prod) + HALF;
  assign shifted = acc >>> FRAC_BITS;

  always_comb begin
    if (shifted > ACC_W'(SAMPLE_MAX)) begin
      sat = SAMPLE_MAX;
    end else if (shifted < ACC_W'(SAMPLE_MIN)) begin
      sat = SAMPLE_MIN;
    end else begin
      sat = shifted[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    case (ctrl.ph_op)
      PH_ADD:  phase_next = ph_sum;
      PH_WRAP: phase_next = ph_ge_one ? phase - ONE : '0;
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    stat.primed    = primed;
    stat.ph_ge_one = ph_ge_one;
    stat.last      = last;
    stat.in_valid  = in_valid;
    stat.out_free  = ~out_valid | out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step       <= STEP_RESET;
      phase           <= '0;
      previous_sample <= '0;
      primed          <= 1'b0;
      cnt             <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        time_step <= cfg_wdata;
      end
      phase <= phase_next;
      if (ctrl.ld_prev) begin
        previous_sample <= cur;
      end
      if (ctrl.set_primed) begin
        primed <= 1'b1;
      end
      if (ctrl.ld_cur) begin
        cnt <= 1'b0;
      end else if (ctrl.emit) begin
        cnt <= 1'b1;
      end
      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_cur) begin
      cur <= sample_in;
    end
    if (ctrl.mul_en) begin
      prod <= diff * frac;
    end
    if (ctrl.emit) begin
      sample_out  <= sat;
      last_of_run <= last;
    end
  end

endmodule

// ----- sv/lir_checker.sv -----
// port-level assertions for the resampler, bound to the top level
module lir_checker import lir_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] sample_out,
  input logic                       last_of_run
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(last_of_run))
    else $error("output changed while stalled");

  // an item takes several steps, so no two accepts in a row
  a_in_spacing: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a new result appears only while an item is being worked on
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while waiting for input");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .sample_out  (out_chan.sample_out),
  .last_of_run (out_chan.last_of_run)
);
